FILE: sv/cu2x_pkg.sv
`timescale 1ns / 1ps

package cu2x_pkg;

    localparam int MAX_PLANE_WIDTH  = 256;
    localparam int MAX_PLANE_HEIGHT = 256;
    localparam int PLANE_DEPTH      = MAX_PLANE_WIDTH * MAX_PLANE_HEIGHT;
    localparam int ADDR_W           = $clog2(PLANE_DEPTH);

    localparam int POS_W    = 9;
    localparam int SAMPLE_W = 8;
    localparam int CFG_W    = 9;
    localparam int SUM_W    = 14;

    // s_tdata field positions
    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + POS_W;
    localparam int SAMPLE_LSB = COL_LSB + POS_W;
    localparam int IN_DATA_W  = 32;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic       load_rd;  // latch read request
        logic       wr;       // store write request
        logic       issue;    // plane read issued this cycle
        logic [1:0] vr;       // issue tap, vertical
        logic [1:0] hc;       // issue tap, horizontal
        logic       acc;      // read data valid this cycle
        logic [1:0] acc_vr;
        logic [1:0] acc_hc;
        logic       v_first;
        logic       v_last;
        logic       h_first;
        logic       h_last;
        logic       emit;     // load output register
    } cu2x_cmd_t;

    typedef struct packed {
        logic rd_in_range;    // incoming read lies inside doubled plane
        logic vsingle;        // latched: even output row
        logic hsingle;        // latched: even output column
    } cu2x_stat_t;

    // 0 acts as 1, above max acts as max
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v, input int maxv);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (int'(v) > maxv)
            r = CFG_W'(maxv);
        else
            r = v;
        return r;
    endfunction

    // taps -1, 9, 9, -1
    function automatic sum_t tap_weight(input logic [SAMPLE_W-1:0] x, input logic [1:0] tap);
        sum_t xs;
        sum_t r;
        xs = sum_t'({1'b0, x});
        case (tap)
            2'd1, 2'd2: r = (xs <<< 3) + xs;
            default:    r = -xs;
        endcase
        return r;
    endfunction

    // (s + 8) >> 4 with floor, clip to 0..255
    function automatic logic [SAMPLE_W-1:0] round_clip(input sum_t s);
        sum_t t;
        sum_t q;
        logic [SAMPLE_W-1:0] r;
        t = s + sum_t'(8);
        q = t >>> 4;
        if (q < 0)
            r = '0;
        else if (q > sum_t'(255))
            r = 8'd255;
        else
            r = q[SAMPLE_W-1:0];
        return r;
    endfunction

    function automatic logic [POS_W-1:0] clamp_idx(input logic signed [POS_W+1:0] i,
                                                   input logic [CFG_W-1:0] dim);
        logic [POS_W-1:0] r;
        if (i < 0)
            r = '0;
        else if (i >= $signed({2'b00, dim}))
            r = dim - CFG_W'(1);
        else
            r = i[POS_W-1:0];
        return r;
    endfunction

endpackage

FILE: sv/cu2x_ram.sv
`timescale 1ns / 1ps

module cu2x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/cu2x_ctrl.sv
`timescale 1ns / 1ps

module cu2x_ctrl
    import cu2x_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  cu2x_stat_t stat,
    output cu2x_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] vr_reg, vr_next;
    logic [1:0] hc_reg, hc_next;
    logic       acc_reg;
    logic [1:0] avr_reg;
    logic [1:0] ahc_reg;
    logic       mvalid_reg, mvalid_next;

    logic       accept;
    logic [1:0] last_r;
    logic [1:0] last_c;
    logic       issue;
    logic       issue_last;
    logic       emit;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid & s_tready;
    assign last_r     = stat.vsingle ? 2'd0 : 2'd3;
    assign last_c     = stat.hsingle ? 2'd0 : 2'd3;
    assign issue      = (state_reg == ST_READ);
    assign issue_last = (vr_reg == last_r) && (hc_reg == last_c);
    assign emit       = (state_reg == ST_EMIT) && (!mvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        vr_next    = vr_reg;
        hc_next    = hc_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && s_tuser == KIND_READ)
                begin
                    vr_next    = 2'd0;
                    hc_next    = 2'd0;
                    state_next = stat.rd_in_range ? ST_READ : ST_EMIT;
                end
            end
            ST_READ:
            begin
                if (vr_reg == last_r)
                begin
                    vr_next = 2'd0;
                    hc_next = hc_reg + 2'd1;
                end
                else
                begin
                    vr_next = vr_reg + 2'd1;
                end
                if (issue_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (emit)
            mvalid_next = 1'b1;
        else if (m_tready)
            mvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vr_reg     <= 2'd0;
            hc_reg     <= 2'd0;
            acc_reg    <= 1'b0;
            avr_reg    <= 2'd0;
            ahc_reg    <= 2'd0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            vr_reg     <= vr_next;
            hc_reg     <= hc_next;
            acc_reg    <= issue;
            avr_reg    <= vr_reg;
            ahc_reg    <= hc_reg;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_tvalid = mvalid_reg;

    always_comb
    begin
        cmd.load_rd = accept && (s_tuser == KIND_READ);
        cmd.wr      = accept && (s_tuser == KIND_WRITE);
        cmd.issue   = issue;
        cmd.vr      = vr_reg;
        cmd.hc      = hc_reg;
        cmd.acc     = acc_reg;
        cmd.acc_vr  = avr_reg;
        cmd.acc_hc  = ahc_reg;
        cmd.v_first = (avr_reg == 2'd0);
        cmd.v_last  = (avr_reg == last_r);
        cmd.h_first = (ahc_reg == 2'd0);
        cmd.h_last  = (avr_reg == last_r) && (ahc_reg == last_c);
        cmd.emit    = emit;
    end

endmodule

FILE: sv/cu2x_dp.sv
`timescale 1ns / 1ps

module cu2x_dp
    import cu2x_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output logic [SAMPLE_W-1:0]  m_tdata,
    output logic                 m_tuser,
    input  cu2x_cmd_t            cmd,
    output cu2x_stat_t           stat
);

    logic [CFG_W-1:0] plane_width_reg;
    logic [CFG_W-1:0] plane_height_reg;
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;

    logic [POS_W-1:0]    in_row;
    logic [POS_W-1:0]    in_col;
    logic [SAMPLE_W-1:0] in_sample;

    logic [POS_W-1:0]    orow_reg;
    logic [POS_W-1:0]    ocol_reg;
    logic                oor_reg;
    sum_t                vacc_reg;
    sum_t                hacc_reg;
    logic [SAMPLE_W-1:0] res_reg;
    logic [SAMPLE_W-1:0] pix_out_reg;
    logic                oor_out_reg;

    logic                   vsingle;
    logic                   hsingle;
    logic signed [POS_W+1:0] ri;
    logic signed [POS_W+1:0] ci;
    logic [POS_W-1:0]       rd_row;
    logic [POS_W-1:0]       rd_col;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      ram_addr;
    logic [SAMPLE_W-1:0]    ram_rdata;

    sum_t                vsum;
    sum_t                hsum;
    logic [SAMPLE_W-1:0] vres;
    logic [SAMPLE_W-1:0] pix;

    assign w_eff = eff_dim(plane_width_reg, MAX_PLANE_WIDTH);
    assign h_eff = eff_dim(plane_height_reg, MAX_PLANE_HEIGHT);

    assign in_row    = s_tdata[ROW_LSB +: POS_W];
    assign in_col    = s_tdata[COL_LSB +: POS_W];
    assign in_sample = s_tdata[SAMPLE_LSB +: SAMPLE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_width_reg  <= CFG_W'(256);
            plane_height_reg <= CFG_W'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_WIDTH:  plane_width_reg  <= cfg_wdata;
                CFG_HEIGHT: plane_height_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    assign stat.rd_in_range = ({1'b0, in_row} < {h_eff, 1'b0}) &&
                              ({1'b0, in_col} < {w_eff, 1'b0});
    assign vsingle      = ~orow_reg[0];
    assign hsingle      = ~ocol_reg[0];
    assign stat.vsingle = vsingle;
    assign stat.hsingle = hsingle;

    // neighbor index: base + tap - 1 for odd positions, base for even
    assign ri = $signed({3'b000, orow_reg[POS_W-1:1]}) + $signed({9'b0, cmd.vr})
              - $signed({10'b0, ~vsingle});
    assign ci = $signed({3'b000, ocol_reg[POS_W-1:1]}) + $signed({9'b0, cmd.hc})
              - $signed({10'b0, ~hsingle});
    assign rd_row = clamp_idx(ri, h_eff);
    assign rd_col = clamp_idx(ci, w_eff);

    assign rd_addr = ADDR_W'(32'(rd_row) * MAX_PLANE_WIDTH + 32'(rd_col));
    assign wr_addr = ADDR_W'(32'(in_row) * MAX_PLANE_WIDTH + 32'(in_col));
    assign wr_en   = cmd.wr && (in_row < h_eff) && (in_col < w_eff);
    assign ram_addr = wr_en ? wr_addr : rd_addr;

    cu2x_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (PLANE_DEPTH)
    ) u_plane (
        .clk   (clk),
        .we    (wr_en),
        .addr  (ram_addr),
        .wdata (in_sample),
        .rdata (ram_rdata)
    );

    // vertical pass, then horizontal pass on the clipped vertical result
    assign vsum = (cmd.v_first ? sum_t'(0) : vacc_reg) + tap_weight(ram_rdata, cmd.acc_vr);
    assign vres = vsingle ? ram_rdata : round_clip(vsum);
    assign hsum = (cmd.h_first ? sum_t'(0) : hacc_reg) + tap_weight(vres, cmd.acc_hc);
    assign pix  = hsingle ? vres : round_clip(hsum);

    always_ff @(posedge clk)
    begin
        if (cmd.load_rd)
        begin
            orow_reg <= in_row;
            ocol_reg <= in_col;
            oor_reg  <= ~stat.rd_in_range;
        end
        if (cmd.acc)
        begin
            vacc_reg <= vsum;
            if (cmd.v_last)
                hacc_reg <= hsum;
            if (cmd.h_last)
                res_reg <= pix;
        end
        if (cmd.emit)
        begin
            pix_out_reg <= oor_reg ? '0 : res_reg;
            oor_out_reg <= oor_reg;
        end
    end

    assign m_tdata = pix_out_reg;
    assign m_tuser = oor_out_reg;

endmodule

FILE: sv/chroma_upsample_2x_4tap.sv
// Chroma 2x upsampler, 4-tap (-1,9,9,-1) separable filter over a stored plane.
// Write request: s_tready stays high, so the next request is taken the cycle after.
// Read request: N reads from the single-port plane RAM, a drain state, then emit
// loads the output register; N = 1 (even row, even col), 4 (one odd), 16 (both odd).
// Out-of-range read: no plane reads, pixel 0. Reset clears control and sets both
// sizes to 256; plane contents are undefined until written.
`timescale 1ns / 1ps

module chroma_upsample_2x_4tap
    import cu2x_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // row[8:0], col[17:9], sample[25:18], zero pad
    input  logic                 s_tuser,   // kind: 0 write, 1 read
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata,   // pixel[7:0]
    output logic                 m_tuser,   // out_of_range
    // register writes: index 0 plane_width, 1 plane_height
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cu2x_cmd_t  cmd;
    cu2x_stat_t stat;

    // Sequencer: walks the tap grid column by column, one RAM read a cycle,
    // and registers the tap tags to line up with the registered read.
    cu2x_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Plane RAM, size registers, edge clamping, vertical and horizontal accumulators,
    // result and output registers.
    cu2x_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
